/* hdl/tssid_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tssid_pkg;

  localparam int SEQ_BITS_DEF   = 12;
  localparam int SHARD_BITS_DEF = 10;
  localparam int TIME_BITS_DEF  = 42;

  localparam int NOW_W       = 48;
  localparam int CFG_W       = 48;
  localparam int SHARD_REG_W = 10;
  localparam int SHARD_MAX_W = 16;
  localparam int SLOT_W      = 64;
  localparam int ID_W        = 64;
  localparam int ID_WIDE_W   = 48 + 16 + 16;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHARD = 2'd0,
    REG_EPOCH = 2'd1,
    REG_DRIFT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic offs;
    logic diff;
    logic cmp;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* hdl/tssid_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module tssid_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  tssid_pkg::status_t  stat,
  output tssid_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFS,
    ST_DIFF,
    ST_CMP,
    ST_COMMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd        = '0;
    cmd.load   = in_valid && in_ready;
    cmd.offs   = (state == ST_OFFS);
    cmd.diff   = (state == ST_DIFF);
    cmd.cmp    = (state == ST_CMP);
    cmd.commit = (state == ST_COMMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            state    <= ST_OFFS;
            in_ready <= 1'b0;
          end else begin
            in_ready <= 1'b1;
          end
        end
        ST_OFFS: state <= ST_DIFF;
        ST_DIFF: state <= ST_CMP;
        ST_CMP:  state <= ST_COMMIT;
        ST_COMMIT: begin
          if (stat.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/tssid_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module tssid_dp #(
  parameter int SEQ_BITS   = tssid_pkg::SEQ_BITS_DEF,
  parameter int SHARD_BITS = tssid_pkg::SHARD_BITS_DEF,
  parameter int TIME_BITS  = tssid_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire [tssid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [tssid_pkg::CFG_W-1:0]       cfg_data,
  input  wire [tssid_pkg::NOW_W-1:0]       now_ms,
  input  tssid_pkg::cmd_t                  cmd,
  output tssid_pkg::status_t               stat,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tssid_pkg::ID_W-1:0]       unique_id,
  output logic                             time_bumped
);

  localparam int SlotCount = 2 ** SEQ_BITS;
  localparam int SlotW     = tssid_pkg::SLOT_W;
  localparam int WideW     = tssid_pkg::ID_WIDE_W;

  logic [tssid_pkg::SHARD_REG_W-1:0] shard_number;
  logic [tssid_pkg::CFG_W-1:0]       epoch_base_ms;
  logic [tssid_pkg::CFG_W-1:0]       drift_offset_ms;

  logic [SlotW-1:0] mem [SlotCount];

  logic [SEQ_BITS-1:0]            seq;
  logic                           wrapped;
  logic [tssid_pkg::NOW_W-1:0]    now_r;
  logic [SlotW-1:0]               rd;
  logic [SlotW-1:0]               off;
  logic [SlotW-1:0]               t;
  logic [SlotW-1:0]               s;
  logic [SlotW-1:0]               tp1;
  logic [SlotW-1:0]               sp1;
  logic                           eq;
  logic                           gt;

  logic [SlotW-1:0]                  sel;
  logic [TIME_BITS-1:0]              time_m;
  logic [tssid_pkg::SHARD_MAX_W-1:0] shard_ext;
  logic [SHARD_BITS-1:0]             shard_f;
  logic [WideW-1:0]                  id_wide;

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shard_number    <= '0;
      epoch_base_ms   <= '0;
      drift_offset_ms <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tssid_pkg::REG_SHARD: shard_number    <= cfg_data[tssid_pkg::SHARD_REG_W-1:0];
        tssid_pkg::REG_EPOCH: epoch_base_ms   <= cfg_data;
        tssid_pkg::REG_DRIFT: drift_offset_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sel       = eq ? tp1 : (gt ? sp1 : t);
    time_m    = sel[TIME_BITS-1:0];
    shard_ext = {{(tssid_pkg::SHARD_MAX_W - tssid_pkg::SHARD_REG_W){1'b0}}, shard_number};
    shard_f   = shard_ext[SHARD_BITS-1:0];
    id_wide   = (WideW'(time_m) << (SEQ_BITS + SHARD_BITS))
              | (WideW'(shard_f) << SEQ_BITS)
              | WideW'(seq);
  end

  // slot table
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd <= mem[seq];
    end
    if (cmd.commit) begin
      mem[seq] <= eq ? tp1 : SlotW'(time_m);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r <= now_ms;
    end
    if (cmd.offs) begin
      off <= {{(SlotW - tssid_pkg::CFG_W){1'b0}}, epoch_base_ms}
           + {{(SlotW - tssid_pkg::CFG_W){drift_offset_ms[tssid_pkg::CFG_W-1]}},
              drift_offset_ms};
    end
    if (cmd.diff) begin
      t <= {{(SlotW - tssid_pkg::NOW_W){1'b0}}, now_r} - off;
      // untouched slots read as zero until the first full lap
      s <= wrapped ? rd : '0;
    end
    if (cmd.cmp) begin
      eq  <= (s == t);
      gt  <= (s > t);
      tp1 <= t + SlotW'(1);
      sp1 <= s + SlotW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        seq <= seq + SEQ_BITS'(1);
        if (seq == {SEQ_BITS{1'b1}}) begin
          wrapped <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      unique_id   <= id_wide[tssid_pkg::ID_W-1:0];
      time_bumped <= eq;
    end
  end

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

  a_seq_step: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (seq == $past(seq) + SEQ_BITS'(1)))
    else $error("sequence did not advance");

endmodule
`default_nettype wire

/* hdl/time_shard_sequence_id_generator.sv */
`timescale 1ns / 1ps
`default_nettype none
// Snowflake-style 64-bit ID generator. Each input beat carries the absolute
// time in ms; the output beat carries time<<(SEQ_BITS+SHARD_BITS) |
// shard<<SEQ_BITS | seq, with tuser set when the sequence slot already held
// that time and the time was advanced by one. One request is processed at a
// time, through offset add, subtract, 64-bit compare and slot write-back,
// against a single-port slot table of 2^SEQ_BITS entries; a new request is
// accepted only once the previous one has been written back. The result sits
// in an output register, so the next request is accepted while it waits; a
// stalled result holds the write-back stage. tready stays low during reset
// and is raised once reset is released. Slots read as zero until the
// sequence counter first wraps, so no clearing pass is needed after reset.
// Configuration must be written only while idle; the block does not check.
module time_shard_sequence_id_generator #(
  parameter int SEQ_BITS   = tssid_pkg::SEQ_BITS_DEF,
  parameter int SHARD_BITS = tssid_pkg::SHARD_BITS_DEF,
  parameter int TIME_BITS  = tssid_pkg::TIME_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [tssid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [tssid_pkg::CFG_W-1:0]      cfg_data,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [tssid_pkg::NOW_W-1:0]      s_axis_tdata,  // now_ms
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [tssid_pkg::ID_W-1:0]      m_axis_tdata,  // unique_id
  output logic [0:0]                      m_axis_tuser   // time_bumped
);

  tssid_pkg::cmd_t    cmd;
  tssid_pkg::status_t stat;
  logic               bumped;

  tssid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tssid_dp #(
    .SEQ_BITS   (SEQ_BITS),
    .SHARD_BITS (SHARD_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .now_ms      (s_axis_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .unique_id   (m_axis_tdata),
    .time_bumped (bumped)
  );

  assign m_axis_tuser = bumped;

endmodule
`default_nettype wire

/* bench/tb_time_shard_sequence_id_generator.sv */
`timescale 1ns / 1ps
module tb_time_shard_sequence_id_generator;

  localparam int RAND_ITEMS  = 1240;
  localparam int RAND_PHASES = 8;
  localparam int NUM_ROWS    = 23;
  localparam int SEQ_W       = tssid_pkg::SEQ_BITS_DEF;

  localparam logic [tssid_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [tssid_pkg::NOW_W-1:0]     NOW_MAX    = 48'hFFFF_FFFF_FFFF;
  localparam logic [tssid_pkg::CFG_W-1:0]     DRIFT_MIN  = 48'h8000_0000_0000;
  localparam logic [tssid_pkg::CFG_W-1:0]     DRIFT_MAX  = 48'h7FFF_FFFF_FFFF;

  typedef struct {
    logic [tssid_pkg::ID_W-1:0] id;
    logic                       bumped;
  } id_beat_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [tssid_pkg::CFG_IDX_W-1:0] idx;
    logic [tssid_pkg::CFG_W-1:0]     value;
    bit                              typed;
    logic [tssid_pkg::ID_W-1:0]      id;
    logic                            bumped;
  } dir_row_t;

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            cfg_we        = 1'b0;
  logic [tssid_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [tssid_pkg::CFG_W-1:0]     cfg_data      = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tssid_pkg::NOW_W-1:0]     s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tssid_pkg::ID_W-1:0]      m_axis_tdata;
  logic [0:0]                      m_axis_tuser;

  logic [tssid_pkg::SHARD_REG_W-1:0] shard_reg;
  logic [tssid_pkg::CFG_W-1:0]       epoch_reg;
  logic [tssid_pkg::CFG_W-1:0]       drift_reg;
  logic [SEQ_W-1:0]                  seq_ctr;
  logic [tssid_pkg::SLOT_W-1:0]      slot_time [1 << SEQ_W];

  id_beat_t pending_ids[$];
  int       fail_count    = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;

  always #2 clk = ~clk;

  time_shard_sequence_id_generator DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic void apply_reg(input logic [tssid_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [tssid_pkg::CFG_W-1:0] value);
    case (idx)
      tssid_pkg::REG_SHARD: begin
        shard_reg = value[tssid_pkg::SHARD_REG_W-1:0];
      end
      tssid_pkg::REG_EPOCH: begin
        epoch_reg = value;
      end
      tssid_pkg::REG_DRIFT: begin
        drift_reg = value;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [63:0] time_offset();
    return 64'(epoch_reg) + {{16{drift_reg[tssid_pkg::CFG_W-1]}}, drift_reg};
  endfunction

  function automatic id_beat_t next_unique_id(input logic [tssid_pkg::NOW_W-1:0] now);
    logic [63:0]      t;
    logic [63:0]      s;
    logic [SEQ_W-1:0] seq;
    id_beat_t         r;
    t = 64'(now) - time_offset();
    seq = seq_ctr;
    seq_ctr = seq_ctr + SEQ_W'(1);
    s = slot_time[seq];
    r.bumped = 1'b0;
    if (s == t) begin
      // slot keeps the unmasked t+1
      t = t + 64'd1;
      slot_time[seq] = t;
      r.bumped = 1'b1;
    end else if (s > t) begin
      t = s + 64'd1;
    end
    t[63:tssid_pkg::TIME_BITS_DEF] = '0;
    if (!r.bumped) begin
      slot_time[seq] = t;
    end
    r.id = {t[tssid_pkg::TIME_BITS_DEF-1:0], shard_reg, seq};
    return r;
  endfunction

  task automatic cfg_write(input logic [tssid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tssid_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    apply_reg(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_ids.size() != 0) @(posedge clk);
  endtask

  task automatic send_now(input logic [tssid_pkg::NOW_W-1:0] now, input bit typed,
                          input id_beat_t want);
    id_beat_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    got = next_unique_id(now);
    if (typed) begin
      got = want;
    end
    pending_ids = {pending_ids, got};
  endtask

  always @(posedge clk) begin : result_check
    id_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_ids.size() == 0) begin
        $error("unique_id beat with nothing pending: actual %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_ids.pop_front();
        if (m_axis_tdata !== want.id) begin
          $error("unique_id: expected %h, actual %h", want.id, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.bumped) begin
          $error("time_bumped: expected %0b, actual %0b", want.bumped, m_axis_tuser[0]);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin : stimulus
    dir_row_t    rows [NUM_ROWS];
    id_beat_t    want;
    logic [47:0] base_epoch;
    logic [63:0] off;
    longint      rel;
    longint      k;
    int          r;
    shard_reg = '0;
    epoch_reg = '0;
    drift_reg = '0;
    seq_ctr   = '0;
    foreach (slot_time[i]) slot_time[i] = '0;
    want = '{id: '0, bumped: 1'b0};

    rows = '{
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd0,              1, 64'h0000_0000_0040_0000, 1'b1},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, NOW_MAX,            1, 64'hFFFF_FFFF_FFC0_0001, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd5,              1, 64'h0000_0000_0140_0002, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_SHARD, 48'h3FF,            0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd7,              1, 64'h0000_0000_01FF_F003, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_EPOCH, 48'd100,            0, '0, 1'b0},
      // epoch later than now, subtraction wraps
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd50,             0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd100,            1, 64'h0000_0000_007F_F005, 1'b1},
      '{ROW_CFG,  tssid_pkg::REG_DRIFT, DRIFT_MIN,          0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd0,              0, '0, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_DRIFT, DRIFT_MAX,          0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, NOW_MAX,            0, '0, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_EPOCH, NOW_MAX,            0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd0,              0, '0, 1'b0},
      // write to an index past the register list is dropped
      '{ROW_CFG,  REG_UNUSED,           48'hFFFF_FFFF_FFFF, 0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd1,              0, '0, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_EPOCH, 48'd0,              0, '0, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_DRIFT, 48'hFFFF_FFFF_FFFF, 0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'd0,              0, '0, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_SHARD, 48'hFFFF_FFFF_FC00, 0, '0, 1'b0},
      '{ROW_CFG,  tssid_pkg::REG_DRIFT, 48'd0,              0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'hAAAA_AAAA_AAAA, 0, '0, 1'b0},
      '{ROW_ITEM, tssid_pkg::REG_SHARD, 48'h5555_5555_5555, 0, '0, 1'b0}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        cfg_write(rows[i].idx, rows[i].value);
      end else begin
        want.id     = rows[i].id;
        want.bumped = rows[i].bumped;
        send_now(rows[i].value, rows[i].typed, want);
      end
    end

    // most phases share one time offset so slot times stay comparable across phases
    base_epoch = {4'b0001, 12'($urandom), 32'($urandom)};
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          send_idle_pct = 66;
          recv_idle_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_idle_pct = 66;
        end
        default: begin
          send_idle_pct = 27;
          recv_idle_pct = 27;
        end
      endcase
      if (ph == 2) begin
        cfg_write(tssid_pkg::REG_SHARD, 48'h3FF);
        cfg_write(tssid_pkg::REG_EPOCH, NOW_MAX);
        cfg_write(tssid_pkg::REG_DRIFT, DRIFT_MAX);
      end else if (ph == 5) begin
        cfg_write(tssid_pkg::REG_SHARD, 48'd0);
        cfg_write(tssid_pkg::REG_EPOCH, 48'd0);
        cfg_write(tssid_pkg::REG_DRIFT, DRIFT_MIN);
      end else begin
        k = longint'($urandom_range(1 << 20)) - (1 << 19);
        cfg_write(tssid_pkg::REG_SHARD, 48'($urandom));
        cfg_write(tssid_pkg::REG_EPOCH, 48'(64'(base_epoch) + 64'(k)));
        cfg_write(tssid_pkg::REG_DRIFT, 48'(-k));
      end
      off = time_offset();
      rel = $urandom_range(15);
      for (int n = 0; n < RAND_ITEMS / RAND_PHASES; n++) begin
        r = $urandom_range(99);
        if (r < 40) begin
        end else if (r < 60) begin
          rel = rel + 1;
        end else if (r < 70) begin
          rel = rel - $urandom_range(64);
        end else if (r < 80) begin
          rel = $urandom_range(15);
        end else if (r < 92) begin
          rel = rel + $urandom_range(256);
        end
        if (r >= 92) begin
          send_now(48'({$urandom, $urandom}), 1'b0, want);
        end else begin
          send_now(48'(off + 64'(rel)), 1'b0, want);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
